/* rtl/modexp_pkg.sv */
// Package: word width, register indexes and the modular add used by the core.
`timescale 1ns / 1ps
package modexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_MODULUS  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_EXPONENT = IDX_BITS'(1);

  typedef logic [WORD_BITS-1:0] word_t;

  // (a + b) mod m, for a, b < m
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] t;
    word_t              r;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      r = t[WORD_BITS-1:0];
    end else begin
      r = s[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/modular_exponentiation_core.sv */
// Modular exponentiation core: base^exponent mod modulus with one shared modular adder.
// A reduction of the base comes first, then one squaring per exponent bit and one multiply per set bit;
// a modulus below 2 skips all of these and yields 0.
// Each modular product runs bit by bit over the multiplier: the shared adder doubles, then adds the multiplicand.
// One request at a time; the next is taken once the result sits in the output register.
// Reset (synchronous, rst_n low): modulus 2, exponent 1, core idle, no result pending.
`timescale 1ns / 1ps
module modular_exponentiation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [modexp_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [modexp_pkg::WORD_BITS-1:0]  cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [modexp_pkg::WORD_BITS-1:0]  in_tdata,   // [31:0] base_value
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [modexp_pkg::WORD_BITS-1:0]  out_tdata   // [31:0] power_result
);
  import modexp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [1:0] K_RED = 2'd0;
  localparam logic [1:0] K_SQR = 2'd1;
  localparam logic [1:0] K_MUL = 2'd2;

  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(WORD_BITS - 1);

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic                ph_r, ph_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] ecnt_r, ecnt_nxt;
  word_t               mod_r, mod_nxt;
  word_t               exp_r, exp_nxt;
  word_t               x_r, x_nxt;
  word_t               a_r, a_nxt;
  word_t               b_r, b_nxt;
  word_t               e_r, e_nxt;
  word_t               p_r, p_nxt;
  word_t               base_r, base_nxt;
  logic                ov_r, ov_nxt;
  word_t               od_r, od_nxt;

  word_t               op_y;
  word_t               sum;
  word_t               p_new;
  logic                mul_done;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // shared modular adder: double on phase 0, add multiplicand on phase 1 when the multiplier's top bit is set
  assign op_y     = ph_r ? (b_r[WORD_BITS-1] ? a_r : '0) : x_r;
  assign sum      = add_mod(x_r, op_y, mod_r);
  assign mul_done = ph_r && (cnt_r == LAST_BIT);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    ecnt_nxt  = ecnt_r;
    mod_nxt   = mod_r;
    exp_nxt   = exp_r;
    x_nxt     = x_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    p_nxt     = p_r;
    base_nxt  = base_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    p_new     = p_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODULUS:  mod_nxt = cfg_data;
        REG_EXPONENT: exp_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (mod_r < word_t'(2)) begin
            p_nxt     = '0;
            state_nxt = S_FIN;
          end else begin
            // reduce base: product 1 * base taken mod modulus
            a_nxt     = word_t'(1);
            b_nxt     = in_tdata;
            x_nxt     = '0;
            ph_nxt    = 1'b0;
            cnt_nxt   = '0;
            kind_nxt  = K_RED;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        x_nxt  = sum;
        ph_nxt = ~ph_r;
        if (ph_r) begin
          b_nxt   = b_r << 1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (mul_done) begin
          x_nxt   = '0;
          cnt_nxt = '0;
          p_new   = sum;
          unique case (kind_r)
            K_RED: begin
              base_nxt = sum;
              p_nxt    = word_t'(1);
              e_nxt    = exp_r;
              ecnt_nxt = '0;
              a_nxt    = word_t'(1);
              b_nxt    = word_t'(1);
              kind_nxt = K_SQR;
            end
            K_SQR: begin
              p_nxt = sum;
              if (e_r[WORD_BITS-1]) begin
                a_nxt    = sum;
                b_nxt    = base_r;
                kind_nxt = K_MUL;
              end
            end
            default: begin
              p_nxt = sum;
            end
          endcase
          // advance to the next exponent bit
          if ((kind_r == K_MUL) || ((kind_r == K_SQR) && !e_r[WORD_BITS-1])) begin
            e_nxt    = e_r << 1;
            ecnt_nxt = ecnt_r + 1'b1;
            if (ecnt_r == LAST_BIT) begin
              state_nxt = S_FIN;
            end else begin
              a_nxt    = p_new;
              b_nxt    = p_new;
              kind_nxt = K_SQR;
            end
          end
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = p_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_RED;
      ph_r    <= 1'b0;
      cnt_r   <= '0;
      ecnt_r  <= '0;
      mod_r   <= word_t'(2);
      exp_r   <= word_t'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      ecnt_r  <= ecnt_nxt;
      mod_r   <= mod_nxt;
      exp_r   <= exp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    e_r    <= e_nxt;
    p_r    <= p_nxt;
    base_r <= base_nxt;
    od_r   <= od_nxt;
  end

endmodule
